@@ hw/rtl/tcec_pkg.sv @@
// Shared types and constants of the text console escape controller.
package tcec_pkg;

  // Console geometry.
  localparam logic [7:0] COLUMNS       = 8'd200;
  localparam logic [6:0] WRAP_LINE     = 7'd112;
  localparam logic [6:0] VISIBLE_LINES = 7'd55;
  localparam logic [6:0] MIRROR_LINE   = 7'd57;

  // Colors in ARGB.
  localparam logic [31:0] DEFAULT_FG = 32'hFFF2EFDE;
  localparam logic [31:0] DEFAULT_BG = 32'hFF202020;
  localparam logic [31:0] COLOR_RED    = 32'hFFDE382B;
  localparam logic [31:0] COLOR_YELLOW = 32'hFFFFC706;
  localparam logic [31:0] COLOR_CYAN   = 32'hFF2CB5E9;
  localparam logic [31:0] COLOR_GRAY   = 32'hFF808080;

  // SGR codes that the parser recognizes.
  localparam logic [7:0] SGR_RESET  = 8'd0;
  localparam logic [7:0] SGR_RED    = 8'd31;
  localparam logic [7:0] SGR_YELLOW = 8'd33;
  localparam logic [7:0] SGR_CYAN   = 8'd36;
  localparam logic [7:0] SGR_GRAY   = 8'd90;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ESC   = 8'h1B;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_SGR   = 8'h6D;
  localparam logic [7:0] CHAR_CLEAR = 8'h4A;

  // Cell command codes on the result channel.
  localparam logic [2:0] OP_GLYPH        = 3'd0;
  localparam logic [2:0] OP_CLEAR_CELL   = 3'd1;
  localparam logic [2:0] OP_CURSOR       = 3'd2;
  localparam logic [2:0] OP_CLEAR_ROW    = 3'd3;
  localparam logic [2:0] OP_CLEAR_BAND   = 3'd4;
  localparam logic [2:0] OP_SET_SCROLL   = 3'd5;
  localparam logic [2:0] OP_CLEAR_SCREEN = 3'd6;

  // Queue between front and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Kind of work a character leaves for the back end.
  typedef enum logic [2:0] {
    KIND_GLYPH,
    KIND_BSPACE,
    KIND_CRET,
    KIND_NEWLINE,
    KIND_CLEAR
  } kind_t;

  // One classified character with everything its commands need.
  typedef struct packed {
    kind_t       kind;
    logic        scroll_en;
    logic [5:0]  scroll_rows;
    logic [6:0]  band_row;
    logic [6:0]  row;
    logic [7:0]  col_a;
    logic [7:0]  col_b;
    logic [7:0]  glyph;
    logic [31:0] fore;
    logic [31:0] back;
  } bundle_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic                   full;
    logic                   nonempty;
    logic [QUEUE_CNT_W-1:0] count;
  } q_status_t;

  // One cell command.
  typedef struct packed {
    logic [2:0]  op;
    logic [6:0]  row;
    logic [7:0]  column;
    logic [7:0]  glyph;
    logic [31:0] fore;
    logic [31:0] back;
    logic [5:0]  scroll;
    logic        last;
  } cmd_t;

endpackage

@@ hw/rtl/tcec_front.sv @@
// Front end: escape parser, cursor and color state, classification of characters.
module tcec_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_char_code,
  input  tcec_pkg::q_status_t  q_status,
  output logic                 push_valid,
  output tcec_pkg::bundle_t    push_data
);

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_NUMBER
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic [31:0] fore_r, fore_nxt;
  logic [31:0] back_r, back_nxt;
  logic [6:0]  line_r, line_nxt;
  logic [7:0]  col_r, col_nxt;

  logic        accept;
  logic        digit;
  logic [11:0] acc_wide;
  logic [6:0]  line_inc;
  logic        produce;

  // A character is taken whenever the queue has room for its work.
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign digit    = (in_char_code >= 8'h30) && (in_char_code <= 8'h39);
  assign acc_wide = {4'b0, acc_r} * 12'd10 + {8'b0, in_char_code[3:0]};
  assign line_inc = line_r + 7'd1;

  // Next state of parser, cursor and colors, and the bundle for the back end.
  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    fore_nxt  = fore_r;
    back_nxt  = back_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    produce   = 1'b0;
    push_data = '0;
    push_data.kind  = tcec_pkg::KIND_GLYPH;
    push_data.row   = line_r;
    push_data.col_a = col_r;
    push_data.glyph = in_char_code;
    push_data.fore  = fore_r;
    push_data.back  = back_r;

    case (mode_r)
      MODE_NORMAL: begin
        if (in_char_code == tcec_pkg::CHAR_LF) begin
          produce        = 1'b1;
          push_data.kind = tcec_pkg::KIND_NEWLINE;
          if (line_inc == tcec_pkg::WRAP_LINE) begin
            line_nxt              = tcec_pkg::VISIBLE_LINES;
            push_data.scroll_en   = 1'b1;
            push_data.scroll_rows = '0;
            push_data.band_row    = tcec_pkg::VISIBLE_LINES + 7'd1;
          end else begin
            line_nxt = line_inc;
            if (line_inc > tcec_pkg::VISIBLE_LINES) begin
              push_data.scroll_en   = 1'b1;
              push_data.scroll_rows = 6'(line_inc - tcec_pkg::VISIBLE_LINES);
              push_data.band_row    = line_inc + 7'd1;
            end
          end
          push_data.row = line_nxt;
          col_nxt       = '0;
        end else if (in_char_code == tcec_pkg::CHAR_CR) begin
          produce        = 1'b1;
          push_data.kind = tcec_pkg::KIND_CRET;
          col_nxt        = '0;
        end else if (in_char_code == tcec_pkg::CHAR_ESC) begin
          mode_nxt = MODE_ESCAPE;
        end else if (in_char_code == tcec_pkg::CHAR_BS) begin
          produce        = 1'b1;
          push_data.kind = tcec_pkg::KIND_BSPACE;
          col_nxt        = (col_r != 8'd0) ? col_r - 8'd1 : 8'd0;
          push_data.col_b = col_nxt;
        end else begin
          produce         = 1'b1;
          push_data.kind  = tcec_pkg::KIND_GLYPH;
          col_nxt         = (col_r < tcec_pkg::COLUMNS) ? col_r + 8'd1 : tcec_pkg::COLUMNS;
          push_data.col_b = col_nxt;
        end
      end
      MODE_ESCAPE: begin
        if (digit) begin
          acc_nxt  = {4'b0, in_char_code[3:0]};
          mode_nxt = MODE_NUMBER;
        end
      end
      default: begin
        // Number mode; the unused code behaves the same way.
        if (digit) begin
          acc_nxt = (acc_wide > 12'd255) ? 8'd255 : acc_wide[7:0];
        end else begin
          case (acc_r)
            tcec_pkg::SGR_RESET: begin
              fore_nxt = tcec_pkg::DEFAULT_FG;
              back_nxt = tcec_pkg::DEFAULT_BG;
            end
            tcec_pkg::SGR_RED:    fore_nxt = tcec_pkg::COLOR_RED;
            tcec_pkg::SGR_YELLOW: fore_nxt = tcec_pkg::COLOR_YELLOW;
            tcec_pkg::SGR_CYAN:   fore_nxt = tcec_pkg::COLOR_CYAN;
            tcec_pkg::SGR_GRAY:   fore_nxt = tcec_pkg::COLOR_GRAY;
            default: ;
          endcase
          if (in_char_code == tcec_pkg::CHAR_SGR) begin
            mode_nxt = MODE_NORMAL;
          end else if (in_char_code == tcec_pkg::CHAR_CLEAR) begin
            produce        = 1'b1;
            push_data.kind = tcec_pkg::KIND_CLEAR;
            line_nxt       = '0;
            mode_nxt       = MODE_NORMAL;
          end else begin
            mode_nxt = MODE_ESCAPE;
          end
        end
      end
    endcase
  end

  assign push_valid = accept && produce;

  // State registers change only when a character is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      acc_r  <= '0;
      fore_r <= tcec_pkg::DEFAULT_FG;
      back_r <= tcec_pkg::DEFAULT_BG;
      line_r <= '0;
      col_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      fore_r <= fore_nxt;
      back_r <= back_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

@@ hw/rtl/tcec_queue.sv @@
// Short queue of classified characters between front and back end.
module tcec_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tcec_pkg::bundle_t   push_data,
  input  logic                pop,
  output tcec_pkg::bundle_t   head,
  output tcec_pkg::q_status_t status
);

  tcec_pkg::bundle_t                 entries_r [tcec_pkg::QUEUE_DEPTH];
  logic [tcec_pkg::QUEUE_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [tcec_pkg::QUEUE_CNT_W-1:0]  count_r;

  assign head            = entries_r[rd_ptr_r];
  assign status.count    = count_r;
  assign status.nonempty = (count_r != '0);
  assign status.full     = (count_r == tcec_pkg::QUEUE_CNT_W'(tcec_pkg::QUEUE_DEPTH));

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/tcec_back.sv @@
// Back end: expands each classified character into its cell commands.
module tcec_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tcec_pkg::bundle_t   head,
  input  tcec_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_op,
  output logic [6:0]          out_row,
  output logic [7:0]          out_column,
  output logic [7:0]          out_glyph,
  output logic [31:0]         out_fore_color,
  output logic [31:0]         out_back_color,
  output logic [5:0]          out_scroll_rows,
  output logic                out_mirror,
  output logic                out_last
);

  logic [1:0]     step_r;
  logic           out_valid_r;
  tcec_pkg::cmd_t cmd;
  tcec_pkg::cmd_t cmd_r;
  logic           mirror_r;
  logic           load;

  // Command selected by the kind of the head item and the step within it.
  always_comb begin
    cmd        = '0;
    cmd.row    = head.row;
    cmd.column = head.col_a;
    case (head.kind)
      tcec_pkg::KIND_GLYPH, tcec_pkg::KIND_BSPACE: begin
        if (step_r == 2'd0) begin
          if (head.kind == tcec_pkg::KIND_GLYPH) begin
            cmd.op    = tcec_pkg::OP_GLYPH;
            cmd.glyph = head.glyph;
            cmd.fore  = head.fore;
            cmd.back  = head.back;
          end else begin
            cmd.op   = tcec_pkg::OP_CLEAR_CELL;
            cmd.back = tcec_pkg::DEFAULT_BG;
          end
        end else begin
          cmd.op     = tcec_pkg::OP_CURSOR;
          cmd.column = head.col_b;
          cmd.fore   = tcec_pkg::DEFAULT_FG;
          cmd.last   = 1'b1;
        end
      end
      tcec_pkg::KIND_CRET: begin
        cmd.op   = tcec_pkg::OP_CLEAR_CELL;
        cmd.back = tcec_pkg::DEFAULT_BG;
        cmd.last = 1'b1;
      end
      tcec_pkg::KIND_NEWLINE: begin
        if (head.scroll_en && step_r == 2'd0) begin
          cmd.op     = tcec_pkg::OP_SET_SCROLL;
          cmd.row    = '0;
          cmd.column = '0;
          cmd.scroll = head.scroll_rows;
        end else if (head.scroll_en && step_r == 2'd1) begin
          cmd.op     = tcec_pkg::OP_CLEAR_BAND;
          cmd.row    = head.band_row;
          cmd.column = '0;
          cmd.back   = tcec_pkg::DEFAULT_BG;
        end else begin
          cmd.op   = tcec_pkg::OP_CLEAR_ROW;
          cmd.back = tcec_pkg::DEFAULT_BG;
          cmd.last = 1'b1;
        end
      end
      tcec_pkg::KIND_CLEAR: begin
        cmd.row    = '0;
        cmd.column = '0;
        if (step_r == 2'd0) begin
          cmd.op = tcec_pkg::OP_SET_SCROLL;
        end else begin
          cmd.op   = tcec_pkg::OP_CLEAR_SCREEN;
          cmd.back = tcec_pkg::DEFAULT_BG;
          cmd.last = 1'b1;
        end
      end
      default: begin
        cmd.last = 1'b1;
      end
    endcase
  end

  // A command moves into the output register when that register is free or drains.
  assign load = q_status.nonempty && (!out_valid_r || !out_stall);
  assign pop  = load && cmd.last;

  // Step counter and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      step_r      <= cmd.last ? 2'd0 : step_r + 2'd1;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r    <= cmd;
      mirror_r <= (cmd.op <= tcec_pkg::OP_CLEAR_ROW) && (cmd.row >= tcec_pkg::MIRROR_LINE);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_op          = cmd_r.op;
  assign out_row         = cmd_r.row;
  assign out_column      = cmd_r.column;
  assign out_glyph       = cmd_r.glyph;
  assign out_fore_color  = cmd_r.fore;
  assign out_back_color  = cmd_r.back;
  assign out_scroll_rows = cmd_r.scroll;
  assign out_mirror      = mirror_r;
  assign out_last        = cmd_r.last;

endmodule

@@ hw/rtl/text_console_escape_controller_unit.sv @@
// Top level of the text console escape controller.
// Each character byte is taken whenever the four-entry queue between
// the parser front end and the command back end has room; escape bytes, digits
// and color codes cause no command. The back end sends one cell command per
// cycle unless out_stall holds it, so a character causes one to three commands
// (glyph and backspace two, carriage return one, newline one or three, clear
// screen two), and the result channel sets the sustained rate. Commands of one
// character come out in order with last set on the final one.
module text_console_escape_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_op,
  output logic [6:0]  out_row,
  output logic [7:0]  out_column,
  output logic [7:0]  out_glyph,
  output logic [31:0] out_fore_color,
  output logic [31:0] out_back_color,
  output logic [5:0]  out_scroll_rows,
  output logic        out_mirror,
  output logic        out_last
);

  logic                push_valid;
  tcec_pkg::bundle_t   push_data;
  logic                pop;
  tcec_pkg::bundle_t   head;
  tcec_pkg::q_status_t q_status;

  // Parser and cursor state.
  tcec_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .q_status     (q_status),
    .push_valid   (push_valid),
    .push_data    (push_data)
  );

  // Queue of classified characters.
  tcec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // Command sequencer and output register.
  tcec_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_status        (q_status),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_op          (out_op),
    .out_row         (out_row),
    .out_column      (out_column),
    .out_glyph       (out_glyph),
    .out_fore_color  (out_fore_color),
    .out_back_color  (out_back_color),
    .out_scroll_rows (out_scroll_rows),
    .out_mirror      (out_mirror),
    .out_last        (out_last)
  );

`ifndef SYNTHESIS
  // The queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.count <= tcec_pkg::QUEUE_CNT_W'(tcec_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // A glyph is always followed by its cursor block.
  a_glyph_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_op == tcec_pkg::OP_GLYPH |-> !out_last)
    else $error("glyph command marked last");

  // A scroll change is always followed by a clear command.
  a_scroll_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_op == tcec_pkg::OP_SET_SCROLL |-> !out_last)
    else $error("set scroll command marked last");

  // Mirror only on cell commands in the lower rows.
  a_mirror_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mirror |->
      out_row >= tcec_pkg::MIRROR_LINE && out_op <= tcec_pkg::OP_CLEAR_ROW)
    else $error("mirror set on a command that cannot mirror");
`endif

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the text console escape controller, with a built-in command predictor.
`timescale 1ns / 1ps

module tb;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  // Parser modes as the predictor tracks them.
  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_NUMBER
  } parse_mode_t;

  // One cell command as seen on the result channel.
  typedef struct {
    logic [2:0]  op;
    logic [6:0]  row;
    logic [7:0]  column;
    logic [7:0]  glyph;
    logic [31:0] fore;
    logic [31:0] back;
    logic [5:0]  scroll;
    logic        mirror;
    logic        last;
  } console_cmd_t;

  // One character waiting to be sent; drain makes the sender wait for all commands first.
  typedef struct {
    logic [7:0] code;
    bit         drain;
  } char_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_code = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_op;
  logic [6:0]  out_row;
  logic [7:0]  out_column;
  logic [7:0]  out_glyph;
  logic [31:0] out_fore_color;
  logic [31:0] out_back_color;
  logic [5:0]  out_scroll_rows;
  logic        out_mirror;
  logic        out_last;

  char_item_t   pending_chars[$];
  console_cmd_t expected_cmds[$];
  int           queued_total = 0;
  int           chars_sent = 0;
  int           error_count = 0;
  logic         quiet = 1'b0;

  // Predicted console state.
  parse_mode_t  mode_q;
  logic [7:0]   acc_q;
  logic [31:0]  fore_q;
  logic [31:0]  back_q;
  logic [6:0]   line_q;
  logic [7:0]   col_q;

  text_console_escape_controller_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_op          (out_op),
    .out_row         (out_row),
    .out_column      (out_column),
    .out_glyph       (out_glyph),
    .out_fore_color  (out_fore_color),
    .out_back_color  (out_back_color),
    .out_scroll_rows (out_scroll_rows),
    .out_mirror      (out_mirror),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void push_cmd(input logic [2:0] op, input logic [6:0] row,
                                   input logic [7:0] column, input logic [7:0] glyph,
                                   input logic [31:0] fore, input logic [31:0] back,
                                   input logic [5:0] scroll);
    console_cmd_t cmd;
    cmd.op     = op;
    cmd.row    = row;
    cmd.column = column;
    cmd.glyph  = glyph;
    cmd.fore   = fore;
    cmd.back   = back;
    cmd.scroll = scroll;
    cmd.mirror = (op <= tcec_pkg::OP_CLEAR_ROW) && (row >= tcec_pkg::MIRROR_LINE);
    cmd.last   = 1'b0;
    expected_cmds.push_back(cmd);
  endfunction

  function automatic void reset_console();
    mode_q = MODE_NORMAL;
    acc_q  = 8'd0;
    fore_q = tcec_pkg::DEFAULT_FG;
    back_q = tcec_pkg::DEFAULT_BG;
    line_q = 7'd0;
    col_q  = 8'd0;
  endfunction

  // Work out the commands that one accepted character causes.
  function automatic void predict_commands(input logic [7:0] code);
    int         first_idx;
    int         acc_next;
    logic [6:0] next_line;
    logic       is_digit;
    first_idx = expected_cmds.size();
    is_digit  = (code >= CHAR_ZERO) && (code <= CHAR_NINE);
    if (mode_q == MODE_NORMAL) begin
      if (code == tcec_pkg::CHAR_LF) begin
        next_line = line_q + 7'd1;
        if (next_line == tcec_pkg::WRAP_LINE) begin
          next_line = tcec_pkg::VISIBLE_LINES;
          push_cmd(tcec_pkg::OP_SET_SCROLL, 7'd0, 8'd0, 8'd0, 32'd0, 32'd0, 6'd0);
          push_cmd(tcec_pkg::OP_CLEAR_BAND, next_line + 7'd1, 8'd0, 8'd0, 32'd0,
                   tcec_pkg::DEFAULT_BG, 6'd0);
        end else if (next_line > tcec_pkg::VISIBLE_LINES) begin
          push_cmd(tcec_pkg::OP_SET_SCROLL, 7'd0, 8'd0, 8'd0, 32'd0, 32'd0,
                   6'(next_line - tcec_pkg::VISIBLE_LINES));
          push_cmd(tcec_pkg::OP_CLEAR_BAND, next_line + 7'd1, 8'd0, 8'd0, 32'd0,
                   tcec_pkg::DEFAULT_BG, 6'd0);
        end
        line_q = next_line;
        push_cmd(tcec_pkg::OP_CLEAR_ROW, line_q, col_q, 8'd0, 32'd0,
                 tcec_pkg::DEFAULT_BG, 6'd0);
        col_q = 8'd0;
      end else if (code == tcec_pkg::CHAR_CR) begin
        push_cmd(tcec_pkg::OP_CLEAR_CELL, line_q, col_q, 8'd0, 32'd0,
                 tcec_pkg::DEFAULT_BG, 6'd0);
        col_q = 8'd0;
      end else if (code == tcec_pkg::CHAR_ESC) begin
        mode_q = MODE_ESCAPE;
      end else if (code == tcec_pkg::CHAR_BS) begin
        push_cmd(tcec_pkg::OP_CLEAR_CELL, line_q, col_q, 8'd0, 32'd0,
                 tcec_pkg::DEFAULT_BG, 6'd0);
        if (col_q != 8'd0) col_q = col_q - 8'd1;
        push_cmd(tcec_pkg::OP_CURSOR, line_q, col_q, 8'd0, tcec_pkg::DEFAULT_FG, 32'd0, 6'd0);
      end else begin
        push_cmd(tcec_pkg::OP_GLYPH, line_q, col_q, code, fore_q, back_q, 6'd0);
        if (col_q < tcec_pkg::COLUMNS) col_q = col_q + 8'd1;
        push_cmd(tcec_pkg::OP_CURSOR, line_q, col_q, 8'd0, tcec_pkg::DEFAULT_FG, 32'd0, 6'd0);
      end
    end else if (mode_q == MODE_ESCAPE) begin
      if (is_digit) begin
        acc_q  = code - CHAR_ZERO;
        mode_q = MODE_NUMBER;
      end
    end else begin
      if (is_digit) begin
        acc_next = int'(acc_q) * 10 + int'(code - CHAR_ZERO);
        acc_q    = (acc_next > 255) ? 8'd255 : 8'(acc_next);
      end else begin
        // The color code applies on any terminator.
        case (acc_q)
          tcec_pkg::SGR_RESET: begin
            fore_q = tcec_pkg::DEFAULT_FG;
            back_q = tcec_pkg::DEFAULT_BG;
          end
          tcec_pkg::SGR_RED:    fore_q = tcec_pkg::COLOR_RED;
          tcec_pkg::SGR_YELLOW: fore_q = tcec_pkg::COLOR_YELLOW;
          tcec_pkg::SGR_CYAN:   fore_q = tcec_pkg::COLOR_CYAN;
          tcec_pkg::SGR_GRAY:   fore_q = tcec_pkg::COLOR_GRAY;
          default: ;
        endcase
        if (code == tcec_pkg::CHAR_SGR) begin
          mode_q = MODE_NORMAL;
        end else if (code == tcec_pkg::CHAR_CLEAR) begin
          push_cmd(tcec_pkg::OP_SET_SCROLL, 7'd0, 8'd0, 8'd0, 32'd0, 32'd0, 6'd0);
          push_cmd(tcec_pkg::OP_CLEAR_SCREEN, 7'd0, 8'd0, 8'd0, 32'd0,
                   tcec_pkg::DEFAULT_BG, 6'd0);
          line_q = 7'd0;
          mode_q = MODE_NORMAL;
        end else begin
          mode_q = MODE_ESCAPE;
        end
      end
    end
    if (expected_cmds.size() > first_idx) expected_cmds[$].last = 1'b1;
  endfunction

  function automatic void queue_char(input logic [7:0] code, input bit drain = 1'b0);
    char_item_t item;
    item.code  = code;
    item.drain = drain;
    pending_chars.push_back(item);
    queued_total++;
  endfunction

  function automatic void queue_text(input string s);
    foreach (s[i]) queue_char(s[i]);
  endfunction

  // Escape sequence with a decimal code and the given terminator.
  function automatic void queue_sgr(input int code, input logic [7:0] term);
    queue_char(tcec_pkg::CHAR_ESC);
    queue_text($sformatf("%0d", code));
    queue_char(term);
  endfunction

  function automatic int pick_color_code();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 31;
      2: return 33;
      3: return 36;
      4: return 90;
      5: return $urandom_range(0, 99);
      default: return $urandom_range(100, 9999);
    endcase
  endfunction

  // Sender: holds a stalled item, otherwise loads the next one or idles.
  always @(posedge clk) begin : sender
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall) begin
        // Item still waiting; keep it steady.
      end else if (pending_chars.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_chars[0].drain && (in_valid || expected_cmds.size() != 0)) begin
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 31) begin
        in_valid <= 1'b0;
      end else begin
        in_valid     <= 1'b1;
        in_char_code <= pending_chars[0].code;
        void'(pending_chars.pop_front());
        chars_sent <= chars_sent + 1;
      end
      quiet <= (chars_sent >= 60) && (chars_sent < 160);
    end
  end

  // Monitor: predicts on each accepted item, then compares each accepted command.
  always @(posedge clk) begin : monitor
    console_cmd_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      reset_console();
    end else begin
      if (in_valid && !in_stall) predict_commands(in_char_code);
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          report_error($sformatf("unexpected command op %0d row %0d column %0d",
                                 out_op, out_row, out_column));
        end else begin
          want = expected_cmds.pop_front();
          if (out_op !== want.op)
            report_error($sformatf("op %0d, want %0d", out_op, want.op));
          if (out_row !== want.row)
            report_error($sformatf("row %0d, want %0d", out_row, want.row));
          if (out_column !== want.column)
            report_error($sformatf("column %0d, want %0d", out_column, want.column));
          if (out_glyph !== want.glyph)
            report_error($sformatf("glyph %h, want %h", out_glyph, want.glyph));
          if (out_fore_color !== want.fore)
            report_error($sformatf("fore_color %h, want %h", out_fore_color, want.fore));
          if (out_back_color !== want.back)
            report_error($sformatf("back_color %h, want %h", out_back_color, want.back));
          if (out_scroll_rows !== want.scroll)
            report_error($sformatf("scroll_rows %0d, want %0d", out_scroll_rows, want.scroll));
          if (out_mirror !== want.mirror)
            report_error($sformatf("mirror %b, want %b", out_mirror, want.mirror));
          if (out_last !== want.last)
            report_error($sformatf("last %b, want %b", out_last, want.last));
        end
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < 31);
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int         random_start;
    int         kind;
    logic [7:0] code;
    // Directed: backspace at column 0, byte extremes, control characters.
    queue_char(tcec_pkg::CHAR_BS);
    queue_char(8'h41);
    queue_char(8'hFF);
    queue_char(8'h00);
    queue_char(8'h7F);
    queue_char(tcec_pkg::CHAR_CR);
    queue_char(tcec_pkg::CHAR_LF);
    // Ignored byte in escape mode, then red text.
    queue_char(tcec_pkg::CHAR_ESC);
    queue_char(8'h71);
    queue_text("31m");
    queue_char(8'h78);
    // Saturating number, a non-final terminator, then cyan.
    queue_char(tcec_pkg::CHAR_ESC);
    queue_text("999;36m");
    queue_char(8'h79, 1'b1);
    // Clear screen, which also resets the colors here.
    queue_sgr(0, tcec_pkg::CHAR_CLEAR);

    random_start = queued_total;
    // Enough line feeds to scroll and wrap at the bottom line.
    repeat (113) queue_char(tcec_pkg::CHAR_LF);
    // A line long enough to saturate the column.
    repeat (202) queue_char(8'($urandom_range(8'h20, 8'h7E)));
    queue_char(tcec_pkg::CHAR_CR, 1'b1);

    while (queued_total < random_start + 316 + 15) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        repeat ($urandom_range(1, 8)) begin
          code = 8'($urandom_range(0, 255));
          queue_char((code == tcec_pkg::CHAR_ESC) ? 8'h61 : code);
        end
      end else if (kind < 55) begin
        queue_char(tcec_pkg::CHAR_ESC);
        if ($urandom_range(0, 3) == 0) queue_char(8'($urandom_range(8'h3A, 8'hFF)));
        queue_text($sformatf("%0d", pick_color_code()));
        if ($urandom_range(0, 3) == 0) begin
          queue_char(CHAR_SEMI);
          queue_text($sformatf("%0d", pick_color_code()));
        end
        queue_char(($urandom_range(0, 4) == 0) ? tcec_pkg::CHAR_CLEAR : tcec_pkg::CHAR_SGR);
      end else if (kind < 70) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 2))
            0: queue_char(tcec_pkg::CHAR_LF);
            1: queue_char(tcec_pkg::CHAR_CR);
            default: queue_char(tcec_pkg::CHAR_BS);
          endcase
        end
      end else if (kind < 80) begin
        repeat ($urandom_range(5, 20)) queue_char(tcec_pkg::CHAR_LF);
      end else if (kind < 82) begin
        queue_char(8'h2E, 1'b1);
      end else begin
        queue_char(8'($urandom_range(0, 255)));
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_chars.size() == 0 && !in_valid);
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_cmds.size() != 0)
      report_error($sformatf("%0d commands never arrived", expected_cmds.size()));
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
